// File: hdl/gfp_pkg.sv
// Package for the GNSS binary frame parser: types, codes and register defaults.
`default_nettype none
package gfp_pkg;

    // Input operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes (word addresses)
    localparam logic [1:0] REG_FIRST_SYNC  = 2'd0;
    localparam logic [1:0] REG_SECOND_SYNC = 2'd1;
    localparam logic [1:0] REG_MAX_LENGTH  = 2'd2;
    localparam logic [1:0] REG_TIMEOUT     = 2'd3;

    // Configuration reset values
    localparam logic [7:0]  RST_FIRST_SYNC  = 8'd186;
    localparam logic [7:0]  RST_SECOND_SYNC = 8'd206;
    localparam logic [15:0] RST_MAX_LENGTH  = 16'd256;
    localparam logic [31:0] RST_TIMEOUT     = 32'd100000;

    // Frame parse phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_CLASS   = 3'd4,
        PH_ID      = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_CHECK   = 3'd7
    } t_phase;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_GOOD  = 2'd1,
        KIND_BAD   = 2'd2,
        KIND_ABORT = 2'd3
    } t_kind;

    // Configuration register set
    typedef struct packed {
        logic [7:0]  first_sync_byte;
        logic [7:0]  second_sync_byte;
        logic [15:0] max_length;
        logic [31:0] timeout_ticks;
    } t_cfg;

    // One result item
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] msg_length;
    } t_result;

endpackage
`default_nettype wire

// File: hdl/gfp_cfg_regs.sv
// APB-style configuration register block of the frame parser.
`default_nettype none
module gfp_cfg_regs
    import gfp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_sync_byte  <= RST_FIRST_SYNC;
            r_cfg.second_sync_byte <= RST_SECOND_SYNC;
            r_cfg.max_length       <= RST_MAX_LENGTH;
            r_cfg.timeout_ticks    <= RST_TIMEOUT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_FIRST_SYNC:  r_cfg.first_sync_byte  <= pwdata[7:0];
                REG_SECOND_SYNC: r_cfg.second_sync_byte <= pwdata[7:0];
                REG_MAX_LENGTH:  r_cfg.max_length       <= pwdata[15:0];
                REG_TIMEOUT:     r_cfg.timeout_ticks    <= pwdata;
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            REG_FIRST_SYNC:  prdata = {24'd0, r_cfg.first_sync_byte};
            REG_SECOND_SYNC: prdata = {24'd0, r_cfg.second_sync_byte};
            REG_MAX_LENGTH:  prdata = {16'd0, r_cfg.max_length};
            REG_TIMEOUT:     prdata = r_cfg.timeout_ticks;
            default:         prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/gfp_core.sv
// Frame parse state machine, checksum accumulation and result generation.
`default_nettype none
module gfp_core
    import gfp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic       i_op,
    input  wire logic [7:0] i_data,
    input  wire t_cfg       i_cfg,
    output logic            o_push,
    output t_result         o_result
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_elapsed, n_elapsed;
    logic [15:0] r_frame_length, n_frame_length;
    logic [7:0]  r_frame_class, n_frame_class;
    logic [7:0]  r_frame_id, n_frame_id;
    logic [15:0] r_byte_count, n_byte_count;
    logic [31:0] r_running_sum, n_running_sum;
    logic [31:0] r_received_sum, n_received_sum;

    logic [31:0] elapsed_inc;
    logic        tick_expired;
    logic [15:0] count_inc;
    logic [15:0] len_full;
    logic [15:0] len_words;
    logic [31:0] lane_data;
    logic [31:0] rx_sum_new;
    logic        is_tick;
    logic        is_byte;

    // Place a byte into one lane of a 32-bit little-endian word
    function automatic logic [31:0] byte_lane(input logic [7:0] b, input logic [1:0] lane);
        logic [31:0] w;
        case (lane)
            2'd0:    w = {24'd0, b};
            2'd1:    w = {16'd0, b, 8'd0};
            2'd2:    w = {8'd0, b, 16'd0};
            default: w = {b, 24'd0};
        endcase
        return w;
    endfunction

    // Shared terms
    assign is_tick      = i_accept && (i_op == OP_TICK);
    assign is_byte      = i_accept && (i_op == OP_BYTE);
    assign elapsed_inc  = (r_elapsed == 32'hFFFF_FFFF) ? r_elapsed : r_elapsed + 32'd1;
    assign tick_expired = elapsed_inc > i_cfg.timeout_ticks;
    assign count_inc    = r_byte_count + 16'd1;
    assign len_full     = {i_data, r_frame_length[7:0]};
    assign len_words    = {r_frame_length[15:2], 2'b00};
    assign lane_data    = byte_lane(i_data, r_byte_count[1:0]);
    assign rx_sum_new   = r_received_sum | lane_data;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (is_tick) begin
            if (r_phase != PH_IDLE && tick_expired) begin
                n_phase = PH_IDLE;
            end
        end else if (is_byte) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_data == i_cfg.first_sync_byte) n_phase = PH_SYNC2;
                end
                PH_SYNC2: begin
                    if (i_data == i_cfg.second_sync_byte) n_phase = PH_LEN_LO;
                    else if (i_data != i_cfg.first_sync_byte) n_phase = PH_IDLE;
                end
                PH_LEN_LO: n_phase = PH_LEN_HI;
                PH_LEN_HI: begin
                    n_phase = (len_full <= i_cfg.max_length) ? PH_CLASS : PH_IDLE;
                end
                PH_CLASS: n_phase = PH_ID;
                PH_ID: begin
                    n_phase = (r_frame_length == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    if (count_inc == r_frame_length) n_phase = PH_CHECK;
                end
                PH_CHECK: begin
                    if (count_inc >= 16'd4) n_phase = PH_IDLE;
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // Datapath updates and result
    always_comb begin
        n_elapsed      = r_elapsed;
        n_frame_length = r_frame_length;
        n_frame_class  = r_frame_class;
        n_frame_id     = r_frame_id;
        n_byte_count   = r_byte_count;
        n_running_sum  = r_running_sum;
        n_received_sum = r_received_sum;
        o_push                = 1'b0;
        o_result.kind         = KIND_BYTE;
        o_result.payload_byte = 8'd0;
        o_result.byte_index   = 16'd0;
        o_result.msg_class    = r_frame_class;
        o_result.msg_id       = r_frame_id;
        o_result.msg_length   = r_frame_length;
        if (is_tick) begin
            if (r_phase != PH_IDLE) begin
                n_elapsed = elapsed_inc;
                if (tick_expired) begin
                    o_push        = 1'b1;
                    o_result.kind = KIND_ABORT;
                end
            end
        end else if (is_byte) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_data == i_cfg.first_sync_byte) n_elapsed = 32'd0;
                end
                PH_LEN_LO: n_frame_length = {8'd0, i_data};
                PH_LEN_HI: n_frame_length = len_full;
                PH_CLASS:  n_frame_class  = i_data;
                PH_ID: begin
                    n_frame_id     = i_data;
                    // id, class and length occupy disjoint bit ranges
                    n_running_sum  = {i_data, r_frame_class, r_frame_length};
                    n_byte_count   = 16'd0;
                    n_received_sum = 32'd0;
                end
                PH_PAYLOAD: begin
                    // only whole words enter the sum
                    if (r_byte_count < len_words) n_running_sum = r_running_sum + lane_data;
                    n_byte_count = count_inc;
                    if (count_inc == r_frame_length) begin
                        n_byte_count   = 16'd0;
                        n_received_sum = 32'd0;
                    end
                    o_push                = 1'b1;
                    o_result.kind         = KIND_BYTE;
                    o_result.payload_byte = i_data;
                    o_result.byte_index   = r_byte_count;
                end
                PH_CHECK: begin
                    n_received_sum = rx_sum_new;
                    n_byte_count   = count_inc;
                    if (count_inc >= 16'd4) begin
                        n_byte_count  = 16'd0;
                        o_push        = 1'b1;
                        o_result.kind = (rx_sum_new == r_running_sum) ? KIND_GOOD : KIND_BAD;
                    end
                end
                default: ;
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_elapsed      <= 32'd0;
            r_frame_length <= 16'd0;
            r_frame_class  <= 8'd0;
            r_frame_id     <= 8'd0;
            r_byte_count   <= 16'd0;
            r_running_sum  <= 32'd0;
            r_received_sum <= 32'd0;
        end else begin
            r_phase        <= n_phase;
            r_elapsed      <= n_elapsed;
            r_frame_length <= n_frame_length;
            r_frame_class  <= n_frame_class;
            r_frame_id     <= n_frame_id;
            r_byte_count   <= n_byte_count;
            r_running_sum  <= n_running_sum;
            r_received_sum <= n_received_sum;
        end
    end

    // Checksum byte counter never leaves one word
    a_check_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CHECK) |-> (r_byte_count < 16'd4))
        else $error("checksum byte count out of range");

    // A timeout result always leaves the parser idle
    a_abort_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_result.kind == KIND_ABORT) |=> (r_phase == PH_IDLE))
        else $error("parser not idle after timeout");

    // Payload results come only from the payload phase on a byte request
    a_byte_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_result.kind == KIND_BYTE) |-> (is_byte && r_phase == PH_PAYLOAD))
        else $error("payload result outside payload phase");

    // Payload index stays below the frame length
    a_byte_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_byte_count < r_frame_length))
        else $error("payload index beyond frame length");

endmodule
`default_nettype wire

// File: hdl/gfp_out_buf.sv
// Two-entry result buffer between the parser core and the output channel.
`default_nettype none
module gfp_out_buf
    import gfp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_result,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_full   = (r_count == 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign pop      = o_valid & i_ready;
    assign o_result = r_mem[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_result;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)    r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // No write into a full buffer
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("result buffer overflow");

    // Fill count matches pointer distance
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= 2'd2) && ((r_wr_ptr ^ r_rd_ptr) == r_count[0]))
        else $error("result buffer pointers inconsistent");

endmodule
`default_nettype wire

// File: hdl/gnss_binary_frame_parser.sv
// Top level: sync/length binary frame parser with word-sum checksum check.
// A result is held in the registered result buffer before it reaches the output ports.
// Throughput: one request per cycle while o_ready is high; the parse step and the 32-bit
// sum add are combinational. A two-entry result buffer lets input continue while a result
// waits; o_ready drops only when both entries are held.
// Reset (synchronous, active low) idles the parser, empties the buffer, restores registers.
`default_nettype none
module gnss_binary_frame_parser
    import gfp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_data,
    // output channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_payload_byte,
    output logic [15:0]      o_byte_index,
    output logic [7:0]       o_msg_class,
    output logic [7:0]       o_msg_id,
    output logic [15:0]      o_msg_length,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg    cfg;
    logic    accept;
    logic    push;
    logic    full;
    t_result core_result;
    t_result out_result;

    assign o_ready = ~full;
    assign accept  = i_valid & o_ready;

    // Configuration registers
    gfp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Parser core
    gfp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_op     (i_op),
        .i_data   (i_data),
        .i_cfg    (cfg),
        .o_push   (push),
        .o_result (core_result)
    );

    // Result buffer
    gfp_out_buf u_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (core_result),
        .o_full   (full),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    assign o_kind         = out_result.kind;
    assign o_payload_byte = out_result.payload_byte;
    assign o_byte_index   = out_result.byte_index;
    assign o_msg_class    = out_result.msg_class;
    assign o_msg_id       = out_result.msg_id;
    assign o_msg_length   = out_result.msg_length;

endmodule
`default_nettype wire
